/* rtl/cpe_pkg.sv */
// Shared types and constants for the complex polynomial evaluator.
// Used by cpe_front, cpe_queue, cpe_back and complex_polynomial_evaluator.
`default_nettype none

package cpe_pkg;

  localparam int DEF_MAX_DEGREE = 63;
  localparam int DEF_FRAC_BITS  = 16;
  localparam int DATA_W         = 32;
  localparam int POWER_W        = 6;
  localparam int OP_W           = 2;
  localparam int QUEUE_DEPTH    = 2;
  // Width of the accumulator for p1 - p2 + (c << FRAC_BITS).
  localparam int ACC_W          = 2 * DATA_W + 2;

  typedef enum logic [OP_W-1:0] {
    OP_CLEAR = 2'd0,
    OP_SET   = 2'd1,
    OP_EVAL  = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  // One queued command. For a set, a and b carry the coefficient;
  // for an evaluation they carry the point z.
  typedef struct packed {
    op_t                      op;
    logic [POWER_W-1:0]       power;
    logic signed [DATA_W-1:0] a;
    logic signed [DATA_W-1:0] b;
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_LOAD,
    ST_MUL,
    ST_ACC,
    ST_OUT
  } state_t;

endpackage

`default_nettype wire

/* rtl/cpe_front.sv */
// Input side: accepts items, drops those that change nothing and builds commands.
// Depends on cpe_pkg.
`default_nettype none

module cpe_front #(
  parameter int MAX_DEGREE = cpe_pkg::DEF_MAX_DEGREE
) (
  input  wire logic                               in_valid,
  output logic                                    in_stall,
  input  wire logic [cpe_pkg::OP_W-1:0]           op,
  input  wire logic [cpe_pkg::POWER_W-1:0]        power,
  input  wire logic signed [cpe_pkg::DATA_W-1:0]  coef_re,
  input  wire logic signed [cpe_pkg::DATA_W-1:0]  coef_im,
  input  wire logic signed [cpe_pkg::DATA_W-1:0]  z_re,
  input  wire logic signed [cpe_pkg::DATA_W-1:0]  z_im,
  input  wire logic                               queue_full,
  input  wire logic                               clearing,
  output logic                                    push,
  output cpe_pkg::cmd_t                           cmd
);
  import cpe_pkg::*;

  logic keep;

  always_comb begin
    cmd.op    = op_t'(op);
    cmd.power = power;
    cmd.a     = coef_re;
    cmd.b     = coef_im;
    keep      = 1'b0;
    unique case (op_t'(op))
      OP_CLEAR: begin
        keep = 1'b1;
      end
      OP_SET: begin
        keep = (int'(power) <= MAX_DEGREE);
      end
      OP_EVAL: begin
        keep  = 1'b1;
        cmd.a = z_re;
        cmd.b = z_im;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  assign in_stall = queue_full | clearing;
  assign push     = in_valid & ~in_stall & keep;

endmodule

`default_nettype wire

/* rtl/cpe_queue.sv */
// Short command queue between the input side and the evaluation engine.
// Depends on cpe_pkg.
`default_nettype none

module cpe_queue (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  wire cpe_pkg::cmd_t push_cmd,
  output logic               full,
  output logic               head_valid,
  output cpe_pkg::cmd_t      head_cmd,
  input  wire logic          pop
);
  import cpe_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  cmd_t             slot [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full       = (count == CNT_W'(QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head_cmd   = slot[rd_ptr];
  assign do_push    = push & ~full;
  assign do_pop     = pop & head_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/cpe_back.sv */
// Evaluation engine: coefficient memory, clearing sweep, Horner loop and output register.
// Depends on cpe_pkg.
`default_nettype none

module cpe_back #(
  parameter int MAX_DEGREE = cpe_pkg::DEF_MAX_DEGREE,
  parameter int FRAC_BITS  = cpe_pkg::DEF_FRAC_BITS
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              cmd_valid,
  input  wire cpe_pkg::cmd_t                     cmd,
  output logic                                   cmd_pop,
  output logic                                   clearing,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic signed [cpe_pkg::DATA_W-1:0]      value_re,
  output logic signed [cpe_pkg::DATA_W-1:0]      value_im,
  output logic                                   overflow
);
  import cpe_pkg::*;

  localparam int DEPTH = MAX_DEGREE + 1;
  localparam int IDX_W = $clog2(DEPTH);

  state_t state;
  state_t state_next;

  logic [IDX_W-1:0] cnt;
  logic [IDX_W-1:0] cnt_next;

  logic [2*DATA_W-1:0] mem [DEPTH];
  logic [2*DATA_W-1:0] rdata;
  logic [IDX_W-1:0]    raddr;
  logic [IDX_W-1:0]    waddr;
  logic [2*DATA_W-1:0] wdata;
  logic                we;

  logic ld_v;
  logic mul_en;
  logic acc_en;
  logic out_ld;
  logic z_ld;

  logic signed [DATA_W-1:0]   zr;
  logic signed [DATA_W-1:0]   zi;
  logic signed [DATA_W-1:0]   vr;
  logic signed [DATA_W-1:0]   vi;
  logic signed [2*DATA_W-1:0] p_rr;
  logic signed [2*DATA_W-1:0] p_ii;
  logic signed [2*DATA_W-1:0] p_ri;
  logic signed [2*DATA_W-1:0] p_ir;
  logic                       ovf;

  logic signed [DATA_W-1:0] c_re;
  logic signed [DATA_W-1:0] c_im;
  logic signed [ACC_W-1:0]  acc_re;
  logic signed [ACC_W-1:0]  acc_im;
  logic signed [ACC_W-1:0]  sh_re;
  logic signed [ACC_W-1:0]  sh_im;
  logic                     sat_re;
  logic                     sat_im;
  logic signed [DATA_W-1:0] new_re;
  logic signed [DATA_W-1:0] new_im;

  assign clearing = (state == ST_CLEAR);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    cmd_pop    = 1'b0;
    we         = 1'b0;
    waddr      = cnt;
    wdata      = '0;
    raddr      = cnt;
    ld_v       = 1'b0;
    mul_en     = 1'b0;
    acc_en     = 1'b0;
    out_ld     = 1'b0;
    z_ld       = 1'b0;
    unique case (state)
      ST_IDLE: begin
        raddr = IDX_W'(MAX_DEGREE);
        if (cmd_valid) begin
          cmd_pop = 1'b1;
          unique case (cmd.op)
            OP_CLEAR: begin
              cnt_next   = '0;
              state_next = ST_CLEAR;
            end
            OP_SET: begin
              we    = 1'b1;
              waddr = IDX_W'(cmd.power);
              wdata = {cmd.a, cmd.b};
            end
            OP_EVAL: begin
              z_ld       = 1'b1;
              state_next = ST_LOAD;
            end
            default: begin
            end
          endcase
        end
      end
      ST_CLEAR: begin
        we = 1'b1;
        if (cnt == IDX_W'(MAX_DEGREE)) begin
          state_next = ST_IDLE;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      ST_LOAD: begin
        ld_v       = 1'b1;
        cnt_next   = IDX_W'(MAX_DEGREE - 1);
        state_next = ST_MUL;
      end
      ST_MUL: begin
        mul_en     = 1'b1;
        state_next = ST_ACC;
      end
      ST_ACC: begin
        acc_en = 1'b1;
        if (cnt == '0) begin
          state_next = ST_OUT;
        end else begin
          cnt_next   = cnt - 1'b1;
          state_next = ST_MUL;
        end
      end
      ST_OUT: begin
        if (!out_valid || !out_stall) begin
          out_ld     = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

  assign c_re = rdata[2*DATA_W-1:DATA_W];
  assign c_im = rdata[DATA_W-1:0];

  // The coefficient is added before the shift: floor(x/2^F) + c = floor((x + c*2^F)/2^F).
  always_comb begin
    acc_re = ACC_W'(p_rr) - ACC_W'(p_ii) + (ACC_W'(c_re) <<< FRAC_BITS);
    acc_im = ACC_W'(p_ri) + ACC_W'(p_ir) + (ACC_W'(c_im) <<< FRAC_BITS);
    sh_re  = acc_re >>> FRAC_BITS;
    sh_im  = acc_im >>> FRAC_BITS;
    sat_re = !((&sh_re[ACC_W-1:DATA_W-1]) || !(|sh_re[ACC_W-1:DATA_W-1]));
    sat_im = !((&sh_im[ACC_W-1:DATA_W-1]) || !(|sh_im[ACC_W-1:DATA_W-1]));
    if (sat_re) begin
      new_re = sh_re[ACC_W-1] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
    end else begin
      new_re = sh_re[DATA_W-1:0];
    end
    if (sat_im) begin
      new_im = sh_im[ACC_W-1] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
    end else begin
      new_im = sh_im[DATA_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (z_ld) begin
      zr  <= cmd.a;
      zi  <= cmd.b;
      ovf <= 1'b0;
    end
    if (ld_v) begin
      vr <= c_re;
      vi <= c_im;
    end
    if (mul_en) begin
      p_rr <= vr * zr;
      p_ii <= vi * zi;
      p_ri <= vr * zi;
      p_ir <= vi * zr;
    end
    if (acc_en) begin
      vr  <= new_re;
      vi  <= new_im;
      ovf <= ovf | sat_re | sat_im;
    end
    if (out_ld) begin
      value_re <= vr;
      value_im <= vi;
      overflow <= ovf;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_ld) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

endmodule

`default_nettype wire

/* rtl/complex_polynomial_evaluator.sv */
// Top level of the complex polynomial evaluator: input side, command queue and engine.
// Depends on cpe_pkg, cpe_front, cpe_queue and cpe_back.
//
//   Channel  Handshake            Payload
//   input    in_valid / in_stall  op, power, coef_re, coef_im, z_re, z_im
//   output   out_valid / out_stall value_re, value_im, overflow
//
// An evaluation passes the engine through ST_LOAD, then ST_MUL and ST_ACC for each Horner
// step (the four multipliers, then the add, shift and saturate stage), and then ST_OUT.
// A set writes one coefficient; a clear sweeps the whole memory to zero.
// After reset the engine sweeps the memory to zero, and in_stall stays high during
// that and any other sweep and while the queue is full.
// A stalled result waits in the output register while the next items queue up.
`default_nettype none

module complex_polynomial_evaluator #(
  parameter int MAX_DEGREE = cpe_pkg::DEF_MAX_DEGREE,
  parameter int FRAC_BITS  = cpe_pkg::DEF_FRAC_BITS
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic [cpe_pkg::OP_W-1:0]          op,
  input  wire logic [cpe_pkg::POWER_W-1:0]       power,
  input  wire logic signed [cpe_pkg::DATA_W-1:0] coef_re,
  input  wire logic signed [cpe_pkg::DATA_W-1:0] coef_im,
  input  wire logic signed [cpe_pkg::DATA_W-1:0] z_re,
  input  wire logic signed [cpe_pkg::DATA_W-1:0] z_im,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic signed [cpe_pkg::DATA_W-1:0]      value_re,
  output logic signed [cpe_pkg::DATA_W-1:0]      value_im,
  output logic                                   overflow
);
  import cpe_pkg::*;

  cmd_t push_cmd;
  cmd_t head_cmd;
  logic push;
  logic queue_full;
  logic head_valid;
  logic pop;
  logic clearing;

  cpe_front #(
    .MAX_DEGREE(MAX_DEGREE)
  ) u_front (
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .op        (op),
    .power     (power),
    .coef_re   (coef_re),
    .coef_im   (coef_im),
    .z_re      (z_re),
    .z_im      (z_im),
    .queue_full(queue_full),
    .clearing  (clearing),
    .push      (push),
    .cmd       (push_cmd)
  );

  cpe_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_cmd  (push_cmd),
    .full      (queue_full),
    .head_valid(head_valid),
    .head_cmd  (head_cmd),
    .pop       (pop)
  );

  cpe_back #(
    .MAX_DEGREE(MAX_DEGREE),
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .cmd_valid(head_valid),
    .cmd      (head_cmd),
    .cmd_pop  (pop),
    .clearing (clearing),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .value_re (value_re),
    .value_im (value_im),
    .overflow (overflow)
  );

endmodule

`default_nettype wire
